### rtl/bit_pkg.sv
// Package for the binary image thinning block: widths, limits, state codes
// and the neighborhood rule. No dependencies.
`default_nettype none
package bit_pkg;
   localparam int MaxWidthDef  = 256;
   localparam int MaxHeightDef = 256;
   localparam int CfgWidth     = 9;
   localparam int PixOutWidth  = 8;

   localparam logic CsrImageWidth  = 1'b0;
   localparam logic CsrImageHeight = 1'b1;

   localparam logic OpLoad = 1'b0;
   localparam logic OpRead = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_WAIT, ST_MARK, ST_CLEAR, ST_READ
   } state_type;

   // Deletion test on the 3x3 window; n holds p2..p9 in bits 0..7.
   function automatic logic zs_delete(input logic ctr, input logic [7:0] n,
                                      input logic pat);
      logic [3:0] trans;
      logic [3:0] cnt;
      logic m1;
      logic m2;
      trans = '0;
      cnt = '0;
      for (int k = 0; k < 8; k++) begin
         trans = trans + {3'd0, (~n[k] & n[(k + 1) % 8])};
         cnt = cnt + {3'd0, n[k]};
      end
      if (!pat) begin
         m1 = n[0] & n[2] & n[4];
         m2 = n[2] & n[4] & n[6];
      end else begin
         m1 = n[0] & n[2] & n[6];
         m2 = n[0] & n[4] & n[6];
      end
      return ctr && trans == 4'd1 && cnt >= 4'd2 && cnt <= 4'd6 && !m1 && !m2;
   endfunction
endpackage
`default_nettype wire

### rtl/bit_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`default_nettype none
interface bit_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic pixel_in;
   modport source (output valid, output operation, output pixel_in, input ready);
   modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

interface bit_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       last_pixel;
   modport source (output valid, output pixel_out, output last_pixel, input ready);
   modport sink (input valid, input pixel_out, input last_pixel, output ready);
endinterface
`default_nettype wire

### rtl/bit_mem.sv
// Single-port bit memory with registered read, used for image and marks.
// Depends on nothing.
`default_nettype none
module bit_mem #(
   parameter int Depth = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic                     wdata,
   output logic                          rdata
);
   logic mem [Depth];

   // Write-first is not needed; read returns old contents.
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

### rtl/binary_image_thinning_top.sv
// Top level of the binary image thinning block: sequencer, window fetch
// through the shared image port and response register. Uses bit_pkg, bit_if, bit_mem.
//
//   channel | dir | payload
//   req     | in  | operation, pixel_in
//   rsp     | out | pixel_out, last_pixel
//   csr     | in  | csr_we, csr_index, csr_wdata
//
// A load writes the image memory directly; a read passes the memory read
// register, then the response register. The load that completes the image
// starts thinning: per sub-pass, each interior pixel gets its 3x3 window
// read through the single image port and one mark write to the mark memory;
// a clear sweep then clears marked pixels. Reset is synchronous; a stalled
// result holds in the response register; the block takes no item meanwhile.
`default_nettype none
module binary_image_thinning_top
   import bit_pkg::*;
#(
   parameter int MaxWidth  = MaxWidthDef,
   parameter int MaxHeight = MaxHeightDef
) (
   input  wire logic                clock,
   input  wire logic                reset,
   bit_req_if.sink                  req,
   bit_rsp_if.source                rsp,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [CfgWidth-1:0] csr_wdata
);
   localparam int Depth = MaxWidth * MaxHeight;
   localparam int AW = $clog2(Depth);
   localparam int DW = $clog2(MaxWidth + 1);
   localparam int HW = $clog2(MaxHeight + 1);

   logic [CfgWidth-1:0] width_ff, height_ff;
   state_type state_ff, state_in;
   logic [AW:0] load_ff, load_in, read_ff, read_in;
   logic [DW-1:0] x_ff, x_in;
   logic [HW-1:0] y_ff, y_in;
   logic [3:0] k_ff, k_in;
   logic [8:0] win_ff, win_in;
   logic pat_ff, pat_in, chg_ff, chg_in, clr_ff, clr_in;
   logic rv_ff, rv_in, rlast_ff, rlast_in, rpend_ff, rpend_in, plast_ff, plast_in;
   logic [PixOutWidth-1:0] rpix_ff, rpix_in;

   logic [DW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [AW:0] total;
   logic img_we, img_wd, img_rd, mk_we, mk_wd, mk_rd;
   logic [AW-1:0] img_a, mk_a;
   logic [AW+1:0] base, nb;

   // Saturate the registers into the usable range.
   always_comb begin
      if (width_ff < 9'd3) w_eff = DW'(3);
      else if (32'(width_ff) > 32'(MaxWidth)) w_eff = DW'(MaxWidth);
      else w_eff = DW'(width_ff);
      if (height_ff < 9'd3) h_eff = HW'(3);
      else if (32'(height_ff) > 32'(MaxHeight)) h_eff = HW'(MaxHeight);
      else h_eff = HW'(height_ff);
   end

   // Pixel count of the image in use; follows a register write at once.
   assign total = (AW + 1)'(w_eff * h_eff);
   assign base = (AW + 2)'(y_ff * w_eff) + (AW + 2)'(x_ff);

   bit_mem #(.Depth(Depth)) u_img (.clock, .we(img_we), .addr(img_a),
                                   .wdata(img_wd), .rdata(img_rd));
   bit_mem #(.Depth(Depth)) u_mk (.clock, .we(mk_we), .addr(mk_a),
                                  .wdata(mk_wd), .rdata(mk_rd));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_we) begin
         if (csr_index == CsrImageWidth) width_ff <= csr_wdata;
         else height_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         load_ff <= '0;
         read_ff <= '0;
         rv_ff <= 1'b0;
         rpend_ff <= 1'b0;
         chg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff <= load_in;
         read_ff <= read_in;
         rv_ff <= rv_in;
         rpend_ff <= rpend_in;
         chg_ff <= chg_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; k_ff <= k_in; win_ff <= win_in;
      pat_ff <= pat_in; clr_ff <= clr_in; rlast_ff <= rlast_in;
      rpix_ff <= rpix_in; plast_ff <= plast_in;
   end

   assign req.ready = (state_ff == ST_IDLE) && !rv_ff && !rpend_ff;
   assign rsp.valid = rv_ff;
   assign rsp.pixel_out = rpix_ff;
   assign rsp.last_pixel = rlast_ff;

   // Sequencer: load/read service, then window scan and clear sweeps.
   always_comb begin
      logic [AW:0] lp, rp;
      state_in = state_ff;
      load_in = load_ff; read_in = read_ff;
      x_in = x_ff; y_in = y_ff; k_in = k_ff; win_in = win_ff;
      pat_in = pat_ff; chg_in = chg_ff; clr_in = clr_ff;
      rv_in = rv_ff; rlast_in = rlast_ff; rpix_in = rpix_ff;
      rpend_in = rpend_ff; plast_in = plast_ff;
      img_we = 1'b0; img_wd = 1'b0; img_a = '0;
      mk_we = 1'b0; mk_wd = 1'b0; mk_a = AW'(base);
      lp = (load_ff >= total) ? '0 : load_ff;
      rp = (read_ff >= total) ? '0 : read_ff;
      nb = base;
      // Neighbor order: k=0..7 p2..p9, k=8 center.
      unique case (k_ff)
         4'd0: nb = base - (AW + 2)'(w_eff);
         4'd1: nb = base - (AW + 2)'(w_eff) + 1'b1;
         4'd2: nb = base + 1'b1;
         4'd3: nb = base + (AW + 2)'(w_eff) + 1'b1;
         4'd4: nb = base + (AW + 2)'(w_eff);
         4'd5: nb = base + (AW + 2)'(w_eff) - 1'b1;
         4'd6: nb = base - 1'b1;
         4'd7: nb = base - (AW + 2)'(w_eff) - 1'b1;
         default: nb = base;
      endcase
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (rpend_ff) begin
               rpend_in = 1'b0;
               rv_in = 1'b1;
               rpix_in = img_rd ? 8'd255 : 8'd0;
               rlast_in = plast_ff;
            end else if (req.valid && req.ready) begin
               if (req.operation == OpLoad) begin
                  img_we = 1'b1; img_wd = req.pixel_in; img_a = AW'(lp);
                  if (lp + 1'b1 >= total) begin
                     load_in = '0; read_in = '0;
                     x_in = DW'(1); y_in = HW'(1); k_in = '0;
                     pat_in = 1'b0; clr_in = 1'b0; chg_in = 1'b0;
                     state_in = ST_FETCH;
                  end else load_in = lp + 1'b1;
               end else begin
                  img_a = AW'(rp);
                  plast_in = (rp + 1'b1 == total);
                  read_in = (rp + 1'b1 >= total) ? '0 : rp + 1'b1;
                  rpend_in = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            // Issue window reads one per cycle; capture each read in the next cycle.
            img_a = clr_ff ? AW'(base) : AW'(nb);
            mk_a = AW'(base);
            if (k_ff != 4'd0 && !clr_ff) win_in[k_ff - 1'b1] = img_rd;
            if (clr_ff) state_in = ST_CLEAR;
            else if (k_ff == 4'd8) state_in = ST_WAIT;
            else k_in = k_ff + 1'b1;
         end
         ST_WAIT: begin
            win_in[8] = img_rd;
            state_in = ST_MARK;
         end
         ST_MARK, ST_CLEAR: begin
            if (state_ff == ST_MARK) begin
               mk_we = 1'b1;
               mk_wd = zs_delete(win_ff[8], win_ff[7:0], pat_ff);
            end else if (mk_rd && img_rd) begin
               img_we = 1'b1; img_wd = 1'b0; img_a = AW'(base);
               chg_in = 1'b1;
            end
            k_in = '0;
            state_in = ST_FETCH;
            if ((AW + 2)'(x_ff) + 2'd2 < (AW + 2)'(w_eff)) x_in = x_ff + 1'b1;
            else begin
               x_in = DW'(1);
               if ((AW + 2)'(y_ff) + 2'd2 < (AW + 2)'(h_eff)) y_in = y_ff + 1'b1;
               else begin
                  y_in = HW'(1);
                  if (!clr_ff) clr_in = 1'b1;
                  else begin
                     clr_in = 1'b0;
                     if (pat_ff == 1'b0) pat_in = 1'b1;
                     else if (chg_in) begin
                        pat_in = 1'b0; chg_in = 1'b0;
                     end else begin
                        chg_in = 1'b0;
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for binary_image_thinning_top: loads small binary
// images, lets the block thin them and checks every pixel read back.
// Depends on bit_pkg, bit_if and the RTL of the block.
`default_nettype none
module testbench;
   import bit_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StoreDepth   = MaxWidthDef * MaxHeightDef;
   localparam int IdleLimit    = 400000;
   localparam int LongHold     = 400;
   localparam int ItemsWanted  = 750;

   typedef struct {
      logic [PixOutWidth-1:0] pixel_out;
      logic                   last_pixel;
   } pixel_result_type;

   typedef struct {
      logic                   op;
      logic                   pix;
      bit                     typed;
      logic [PixOutWidth-1:0] pixel_out;
      logic                   last_pixel;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic                csr_index;
   logic [CfgWidth-1:0] csr_wdata;

   bit_req_if req_ch ();
   bit_rsp_if rsp_ch ();

   binary_image_thinning_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's state.
   bit                  image_bits [StoreDepth];
   bit                  pixel_written [StoreDepth];
   bit                  erase_marks [StoreDepth];
   logic [CfgWidth-1:0] width_reg;
   logic [CfgWidth-1:0] height_reg;
   int                  load_pos;
   int                  read_pos;
   bit                  image_done;

   pixel_result_type    expected_pixels [$];
   int                  error_count;
   int                  items_sent;
   int                  long_holds_asked;
   int                  idle_cycles;
   bit                  quiet_mode;
   int                  rect_x0, rect_x1, rect_y0, rect_y1;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, what);
   endtask

   function automatic int used_dim(input logic [CfgWidth-1:0] raw, input int limit);
      if (raw < 3) return 3;
      if (raw > limit) return limit;
      return int'(raw);
   endfunction

   // One sub-pass of the thinning: mark all deletable pixels, then clear them.
   function automatic bit thinning_sweep(input int w, input int h, input bit pattern);
      bit p2, p3, p4, p5, p6, p7, p8, p9;
      int c;
      int trans;
      int cnt;
      bit m1, m2;
      bit any;
      any = 1'b0;
      for (int y = 1; y + 1 < h; y++) begin
         for (int x = 1; x + 1 < w; x++) begin
            c = y * w + x;
            p2 = image_bits[c - w];
            p3 = image_bits[c - w + 1];
            p4 = image_bits[c + 1];
            p5 = image_bits[c + w + 1];
            p6 = image_bits[c + w];
            p7 = image_bits[c + w - 1];
            p8 = image_bits[c - 1];
            p9 = image_bits[c - w - 1];
            trans = (!p2 && p3) + (!p3 && p4) + (!p4 && p5) + (!p5 && p6)
                  + (!p6 && p7) + (!p7 && p8) + (!p8 && p9) + (!p9 && p2);
            cnt = p2 + p3 + p4 + p5 + p6 + p7 + p8 + p9;
            if (!pattern) begin
               m1 = p2 & p4 & p6;
               m2 = p4 & p6 & p8;
            end else begin
               m1 = p2 & p4 & p8;
               m2 = p2 & p6 & p8;
            end
            erase_marks[c] = image_bits[c] && trans == 1 && cnt >= 2 && cnt <= 6
                             && !m1 && !m2;
         end
      end
      for (int y = 1; y + 1 < h; y++) begin
         for (int x = 1; x + 1 < w; x++) begin
            c = y * w + x;
            if (erase_marks[c]) begin
               image_bits[c] = 1'b0;
               any = 1'b1;
            end
         end
      end
      return any;
   endfunction

   // Apply one item to the shadow state; returns 1 when it causes a result.
   function automatic bit predict_pixel(input logic op, input logic pix,
                                        output pixel_result_type res);
      int w, h, total;
      bit changed;
      w = used_dim(width_reg, MaxWidthDef);
      h = used_dim(height_reg, MaxHeightDef);
      total = w * h;
      image_done = 1'b0;
      if (op == OpLoad) begin
         if (load_pos >= total) load_pos = 0;
         image_bits[load_pos] = pix;
         pixel_written[load_pos] = 1'b1;
         load_pos++;
         if (load_pos >= total) begin
            do begin
               changed = thinning_sweep(w, h, 1'b0);
               changed = thinning_sweep(w, h, 1'b1) | changed;
            end while (changed);
            load_pos = 0;
            read_pos = 0;
            image_done = 1'b1;
         end
         return 1'b0;
      end
      if (read_pos >= total) read_pos = 0;
      res.pixel_out = image_bits[read_pos] ? 8'd255 : 8'd0;
      res.last_pixel = (read_pos + 1 == total);
      read_pos++;
      if (read_pos >= total) read_pos = 0;
      return 1'b1;
   endfunction

   // A read is only issued where the pixel it returns was written.
   function automatic bit read_is_safe();
      int total;
      total = used_dim(width_reg, MaxWidthDef) * used_dim(height_reg, MaxHeightDef);
      return pixel_written[(read_pos >= total) ? 0 : read_pos];
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item and wait until the block takes it.
   task automatic send_item(input logic op, input logic pix, input bit typed = 1'b0,
                            input pixel_result_type typed_res = '{8'd0, 1'b0});
      int gap;
      pixel_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (predict_pixel(op, pix, res)) begin
         expected_pixels.push_back(typed ? typed_res : res);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.pixel_in <= pix;
      items_sent++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Wait until every result is in and the block is idle, then write the size.
   task automatic write_dims(input logic [CfgWidth-1:0] w, input logic [CfgWidth-1:0] h);
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CsrImageWidth;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CsrImageHeight;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      width_reg = w;
      height_reg = h;
   endtask

   // Pixel of the random scene: a dense rectangle on a sparse background.
   function automatic logic scene_pixel();
      int w, h, pos, x, y;
      w = used_dim(width_reg, MaxWidthDef);
      h = used_dim(height_reg, MaxHeightDef);
      pos = (load_pos >= w * h) ? 0 : load_pos;
      x = pos % w;
      y = pos / w;
      if (x >= rect_x0 && x <= rect_x1 && y >= rect_y0 && y <= rect_y1) begin
         return $urandom_range(0, 99) < 92;
      end
      return $urandom_range(0, 99) < 8;
   endfunction

   // One phase: new size, a full image with stray reads, a readout, a partial load.
   // Without a full readout only the first few pixels are read back.
   task automatic image_phase(input logic [CfgWidth-1:0] w_raw,
                              input logic [CfgWidth-1:0] h_raw, input bit squeeze,
                              input bit full_readout);
      int w, h, total, extra;
      write_dims(w_raw, h_raw);
      quiet_mode = ($urandom_range(0, 3) == 0);
      w = used_dim(width_reg, MaxWidthDef);
      h = used_dim(height_reg, MaxHeightDef);
      total = w * h;
      rect_x0 = $urandom_range(0, w - 1);
      rect_x1 = $urandom_range(rect_x0, w - 1);
      rect_y0 = $urandom_range(0, h - 1);
      rect_y1 = $urandom_range(rect_y0, h - 1);
      image_done = 1'b0;
      while (!image_done) begin
         if ($urandom_range(0, 9) == 0 && read_is_safe()) send_item(OpRead, $urandom_range(0, 1));
         else send_item(OpLoad, scene_pixel());
      end
      if (squeeze) long_holds_asked++;
      if (full_readout) begin
         repeat (total + $urandom_range(0, 3)) send_item(OpRead, $urandom_range(0, 1));
      end else begin
         repeat ($urandom_range(4, 12)) send_item(OpRead, $urandom_range(0, 1));
      end
      extra = $urandom_range(0, (total - 1 < 12) ? total - 1 : 12);
      repeat (extra) send_item(OpLoad, $urandom_range(0, 1));
   endtask

   // Result side: random ready with gaps, and one long hold when asked.
   initial begin : result_side
      int hold;
      int holds_done;
      hold = 0;
      holds_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result with none expected: pixel %0d last %0b",
                                         rsp_ch.pixel_out, rsp_ch.last_pixel));
            end else begin
               pixel_result_type want;
               want = expected_pixels.pop_front();
               if (rsp_ch.pixel_out !== want.pixel_out)
                  report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                            rsp_ch.pixel_out, want.pixel_out));
               if (rsp_ch.last_pixel !== want.last_pixel)
                  report_mismatch($sformatf("last_pixel %0b, expected %0b",
                                            rsp_ch.last_pixel, want.last_pixel));
            end
         end
         if (holds_done < long_holds_asked) begin
            holds_done++;
            hold = LongHold;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet_mode) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) rsp_ch.ready <= 1'b1;
            else begin
               rsp_ch.ready <= 1'b0;
               if (r >= 96) hold = $urandom_range(10, 40);
            end
         end
      end
   end

   // Watchdog on cycles in which no item moves on either side.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Main sequence.
   initial begin : stimulus
      stim_row_type dir_rows [$];
      stim_row_type row;
      pixel_result_type typed_res;
      error_count = 0;
      items_sent = 0;
      long_holds_asked = 0;
      idle_cycles = 0;
      quiet_mode = 1'b0;
      load_pos = 0;
      read_pos = 0;
      width_reg = 9'd256;
      height_reg = 9'd256;
      foreach (image_bits[i]) begin
         image_bits[i] = 1'b0;
         pixel_written[i] = 1'b0;
         erase_marks[i] = 1'b0;
      end
      req_ch.valid = 1'b0;
      req_ch.operation = OpLoad;
      req_ch.pixel_in = 1'b0;
      csr_we = 1'b0;
      csr_index = CsrImageWidth;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a solid 3x3 image survives thinning whole; the readout wraps.
      for (int i = 0; i < 9; i++) dir_rows.push_back('{OpLoad, 1'b1, 1'b0, 8'd0, 1'b0});
      for (int i = 0; i < 9; i++) dir_rows.push_back('{OpRead, 1'b0, 1'b1, 8'd255, i == 8});
      dir_rows.push_back('{OpRead, 1'b1, 1'b1, 8'd255, 1'b0});
      for (int i = 0; i < 5; i++) dir_rows.push_back('{OpLoad, 1'b0, 1'b0, 8'd0, 1'b0});
      write_dims(9'd3, 9'd2);
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         typed_res.pixel_out = row.pixel_out;
         typed_res.last_pixel = row.last_pixel;
         send_item(row.op, row.pix, row.typed, typed_res);
      end

      // Lower extremes of the size registers, saturation included.
      image_phase(9'd0, 9'd5, 1'b0, 1'b1);
      image_phase(9'd6, 9'd0, 1'b0, 1'b1);
      image_phase(9'd3, 9'd1, 1'b0, 1'b1);

      // Random small images.
      while (items_sent < ItemsWanted - 500) begin
         image_phase($urandom_range(3, 12), $urandom_range(3, 12), $urandom_range(0, 7) == 0,
                     1'b1);
      end

      // Upper saturation of the width with a long hold on the results.
      image_phase(9'd511, 9'd3, 1'b1, 1'b0);

      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
rtl/bit_pkg.sv
rtl/bit_if.sv
rtl/bit_mem.sv
rtl/binary_image_thinning_top.sv
verif/testbench.sv
